### hdl/lzhc_pkg.sv
// Shared types and constants for the LZ77 hash chain match finder.
// No dependencies; the top level and lzhc_hash import this package.
package lzhc_pkg;

    typedef enum logic [1:0] {
        FN_WRITE  = 2'd0,
        FN_INSERT = 2'd1,
        FN_FIND   = 2'd2,
        FN_CLEAR  = 2'd3
    } func_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_RD01,
        ST_RD2,
        ST_HASH,
        ST_HEAD,
        ST_HEADQ,
        ST_WALK,
        ST_QCHK,
        ST_CMP_RD,
        ST_CMP_EQ,
        ST_CMP_DONE,
        ST_NEXT,
        ST_DONE
    } state_t;

    localparam logic [1:0] REG_DATA_LENGTH = 2'd0;
    localparam logic [1:0] REG_MAX_CHAIN   = 2'd1;
    localparam logic [1:0] REG_MAX_MATCH   = 2'd2;

    localparam logic [16:0] DATA_LENGTH_RST = 17'd0;
    localparam logic [12:0] MAX_CHAIN_RST   = 13'd64;
    localparam logic [8:0]  MAX_MATCH_RST   = 9'd258;

    localparam logic [31:0] HASH_MULT = 32'd2654435761;

endpackage

### hdl/lz77_hash_chain_match_finder.sv
// Top level of the LZ77 hash chain match finder: sequencer, tables and APB registers.
// Depends on lzhc_pkg, lzhc_ram and lzhc_hash.
//
//   channel   ports                                      direction
//   request   s_valid s_ready s_func s_position s_byte_value   in
//   result    m_valid m_ready m_match_length m_match_distance  out
//   config    psel penable pwrite paddr pwdata prdata pready   APB slave
//
// Writes and inserts are sequenced around the single read port of the history
// and head memories. A search then walks the chain: per examined candidate, a walk
// step issues the link fetch, the quick reject is tried once a match is known, and
// the bytes are compared one pair at a time before the compare is closed, since
// one byte compare unit is shared.
// After reset, and for a clear request, a clearing pass over max(2**HASH_BITS,
// WINDOW_SIZE) entries invalidates the head and chain tables; no request is
// taken then. A stalled result is held in the output register and the next
// request is accepted meanwhile; the sequencer only waits if a new result is
// ready while the previous one is still pending.
module lz77_hash_chain_match_finder #(
    parameter int BUFFER_BYTES = 65536,
    parameter int WINDOW_SIZE  = 4096,  // must be a power of two
    parameter int HASH_BITS    = 12,
    parameter int MIN_MATCH    = 3
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [15:0] s_position,
    input  logic [7:0]  s_byte_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [8:0]  m_match_length,
    output logic [12:0] m_match_distance,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lzhc_pkg::*;

    localparam int AW         = $clog2(BUFFER_BYTES);
    localparam int LW         = (AW + 1 > 17) ? AW + 1 : 17;
    localparam int WAW        = $clog2(WINDOW_SIZE);
    localparam int HEAD_COUNT = 1 << HASH_BITS;
    localparam int CLR_DEPTH  = (HEAD_COUNT > WINDOW_SIZE) ? HEAD_COUNT : WINDOW_SIZE;
    localparam int CW         = $clog2(CLR_DEPTH);

    // Configuration registers.
    logic [16:0] data_length_reg;
    logic [12:0] max_chain_reg;
    logic [8:0]  max_match_reg;
    logic        cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_length_reg <= DATA_LENGTH_RST;
            max_chain_reg   <= MAX_CHAIN_RST;
            max_match_reg   <= MAX_MATCH_RST;
        end else if (cfg_we) begin
            case (paddr[3:2])
                REG_DATA_LENGTH: data_length_reg <= pwdata[16:0];
                REG_MAX_CHAIN:   max_chain_reg   <= pwdata[12:0];
                REG_MAX_MATCH:   max_match_reg   <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_DATA_LENGTH: prdata = {15'd0, data_length_reg};
            REG_MAX_CHAIN:   prdata = {19'd0, max_chain_reg};
            REG_MAX_MATCH:   prdata = {23'd0, max_match_reg};
            default:         prdata = 32'd0;
        endcase
    end

    // Effective data length never exceeds the buffer.
    logic [LW-1:0] eff_len;
    assign eff_len = (LW'(data_length_reg) > LW'(BUFFER_BYTES)) ? LW'(BUFFER_BYTES)
                                                                : LW'(data_length_reg);

    // Sequencer and datapath registers.
    state_t          state_reg, state_next;
    func_t           func_reg, func_next;
    logic [15:0]     pos_reg, pos_next;
    logic [7:0]      b0_reg, b0_next, b1_reg, b1_next;
    logic [HASH_BITS-1:0] h_reg, h_next;
    logic            have_reg, have_next;
    logic [15:0]     cand_reg, cand_next;
    logic [12:0]     left_reg, left_next;
    logic [8:0]      best_len_reg, best_len_next;
    logic [16:0]     best_dist_reg, best_dist_next;
    logic [8:0]      n_reg, n_next;
    logic [8:0]      cap_reg, cap_next;
    logic [CW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic            clr_cmd_reg, clr_cmd_next;
    logic            m_valid_reg, m_valid_next;
    logic [8:0]      out_len_reg, out_len_next;
    logic [12:0]     out_dist_reg, out_dist_next;

    // Memory ports. History is kept twice so that two bytes are read per cycle.
    logic            hist_we;
    logic [AW-1:0]   hist_waddr;
    logic            hist_re;
    logic [AW-1:0]   hist_raddr_a, hist_raddr_b;
    logic [7:0]      hist_rdata_a, hist_rdata_b;
    logic            head_we, head_re;
    logic [HASH_BITS-1:0] head_waddr;
    logic [16:0]     head_wdata, head_rdata;
    logic            link_we, link_re;
    logic [WAW-1:0]  link_waddr, link_raddr;
    logic [16:0]     link_wdata, link_rdata;
    logic [HASH_BITS-1:0] hash_val;

    lzhc_ram #(.DEPTH(BUFFER_BYTES), .WIDTH(8)) u_hist_a (
        .aclk(aclk), .we(hist_we), .waddr(hist_waddr), .wdata(s_byte_value),
        .re(hist_re), .raddr(hist_raddr_a), .rdata(hist_rdata_a)
    );
    lzhc_ram #(.DEPTH(BUFFER_BYTES), .WIDTH(8)) u_hist_b (
        .aclk(aclk), .we(hist_we), .waddr(hist_waddr), .wdata(s_byte_value),
        .re(hist_re), .raddr(hist_raddr_b), .rdata(hist_rdata_b)
    );
    // The head read is issued while the hash register already holds this request's hash.
    lzhc_ram #(.DEPTH(HEAD_COUNT), .WIDTH(17)) u_heads (
        .aclk(aclk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
        .re(head_re), .raddr(hash_val), .rdata(head_rdata)
    );
    lzhc_ram #(.DEPTH(WINDOW_SIZE), .WIDTH(17)) u_links (
        .aclk(aclk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
        .re(link_re), .raddr(link_raddr), .rdata(link_rdata)
    );
    lzhc_hash #(.HASH_BITS(HASH_BITS)) u_hash (
        .aclk(aclk), .word({hist_rdata_a, b1_reg, b0_reg}), .hash(hash_val)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            clr_cmd_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            clr_cmd_reg <= clr_cmd_next;
            m_valid_reg <= m_valid_next;
        end
        func_reg      <= func_next;
        pos_reg       <= pos_next;
        b0_reg        <= b0_next;
        b1_reg        <= b1_next;
        h_reg         <= h_next;
        have_reg      <= have_next;
        cand_reg      <= cand_next;
        left_reg      <= left_next;
        best_len_reg  <= best_len_next;
        best_dist_reg <= best_dist_next;
        n_reg         <= n_next;
        cap_reg       <= cap_next;
        out_len_reg   <= out_len_next;
        out_dist_reg  <= out_dist_next;
    end

    always_comb begin
        logic [LW-1:0] sum_a, sum_b, s_pos_ext, rem;
        logic [16:0]   diff;
        state_next     = state_reg;
        func_next      = func_reg;
        pos_next       = pos_reg;
        b0_next        = b0_reg;
        b1_next        = b1_reg;
        h_next         = h_reg;
        have_next      = have_reg;
        cand_next      = cand_reg;
        left_next      = left_reg;
        best_len_next  = best_len_reg;
        best_dist_next = best_dist_reg;
        n_next         = n_reg;
        cap_next       = cap_reg;
        clr_cnt_next   = clr_cnt_reg;
        clr_cmd_next   = clr_cmd_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        out_len_next   = out_len_reg;
        out_dist_next  = out_dist_reg;
        s_ready        = 1'b0;
        hist_we        = 1'b0;
        hist_re        = 1'b0;
        head_we        = 1'b0;
        head_re        = 1'b0;
        link_we        = 1'b0;
        link_re        = 1'b0;
        head_waddr     = h_reg;
        head_wdata     = {1'b1, pos_reg};
        link_waddr     = pos_reg[WAW-1:0];
        link_wdata     = head_rdata;
        link_raddr     = cand_reg[WAW-1:0];
        s_pos_ext      = LW'(s_position);
        hist_waddr     = s_pos_ext[AW-1:0];
        sum_a          = LW'(pos_reg);
        sum_b          = LW'(cand_reg);
        diff           = {1'b0, pos_reg} - {1'b0, cand_reg};
        rem            = eff_len - LW'(pos_reg);

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    func_next     = func_t'(s_func);
                    pos_next      = s_position;
                    best_len_next = '0;
                    case (func_t'(s_func))
                        FN_WRITE: begin
                            hist_we    = s_pos_ext < LW'(BUFFER_BYTES);
                            state_next = ST_DONE;
                        end
                        FN_CLEAR: begin
                            clr_cnt_next = '0;
                            clr_cmd_next = 1'b1;
                            state_next   = ST_CLEAR;
                        end
                        default: begin
                            if (s_pos_ext + LW'(MIN_MATCH) > eff_len) begin
                                state_next = ST_DONE;
                            end else begin
                                state_next = ST_RD01;
                            end
                        end
                    endcase
                end
            end
            ST_CLEAR: begin
                head_we      = 1'b1;
                head_waddr   = clr_cnt_reg[HASH_BITS-1:0];
                head_wdata   = '0;
                link_we      = 1'b1;
                link_waddr   = clr_cnt_reg[WAW-1:0];
                link_wdata   = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CW'(CLR_DEPTH - 1)) begin
                    state_next = clr_cmd_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_RD01: begin
                sum_b      = LW'(pos_reg) + LW'(1);
                hist_re    = 1'b1;
                cap_next   = (rem > LW'(max_match_reg)) ? max_match_reg : rem[8:0];
                state_next = ST_RD2;
            end
            ST_RD2: begin
                b0_next    = hist_rdata_a;
                b1_next    = hist_rdata_b;
                sum_a      = LW'(pos_reg) + LW'(2);
                hist_re    = 1'b1;
                state_next = ST_HASH;
            end
            ST_HASH: begin
                // The hash unit registers the product of the three bytes now.
                state_next = ST_HEAD;
            end
            ST_HEAD: begin
                h_next     = hash_val;
                state_next = ST_HEADQ;
            end
            ST_HEADQ: begin
                if (func_reg == FN_INSERT) begin
                    link_we    = 1'b1;
                    head_we    = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    have_next  = head_rdata[16];
                    cand_next  = head_rdata[15:0];
                    left_next  = max_chain_reg;
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (!have_reg || left_reg == '0) begin
                    state_next = ST_DONE;
                end else if (cand_reg >= pos_reg || diff > 17'(WINDOW_SIZE)) begin
                    state_next = ST_DONE;
                end else begin
                    left_next = left_reg - 1'b1;
                    link_re   = 1'b1;
                    n_next    = '0;
                    if (best_len_reg == '0) begin
                        state_next = ST_CMP_RD;
                    end else begin
                        sum_a      = LW'(pos_reg) + LW'(best_len_reg);
                        sum_b      = LW'(cand_reg) + LW'(best_len_reg);
                        hist_re    = 1'b1;
                        state_next = ST_QCHK;
                    end
                end
            end
            ST_QCHK: begin
                state_next = (hist_rdata_a == hist_rdata_b) ? ST_CMP_RD : ST_NEXT;
            end
            ST_CMP_RD: begin
                if (n_reg >= cap_reg) begin
                    state_next = ST_CMP_DONE;
                end else begin
                    sum_a      = LW'(pos_reg) + LW'(n_reg);
                    sum_b      = LW'(cand_reg) + LW'(n_reg);
                    hist_re    = 1'b1;
                    state_next = ST_CMP_EQ;
                end
            end
            ST_CMP_EQ: begin
                if (hist_rdata_a == hist_rdata_b) begin
                    n_next     = n_reg + 1'b1;
                    state_next = ST_CMP_RD;
                end else begin
                    state_next = ST_CMP_DONE;
                end
            end
            ST_CMP_DONE: begin
                state_next = ST_NEXT;
                if (n_reg > best_len_reg) begin
                    best_len_next  = n_reg;
                    best_dist_next = diff;
                    if (n_reg >= cap_reg) begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_NEXT: begin
                have_next  = link_rdata[16];
                cand_next  = link_rdata[15:0];
                state_next = ST_WALK;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    if (func_reg == FN_FIND && best_len_reg >= 9'(MIN_MATCH)) begin
                        out_len_next  = best_len_reg;
                        out_dist_next = best_dist_reg[12:0];
                    end else begin
                        out_len_next  = '0;
                        out_dist_next = '0;
                    end
                    clr_cmd_next = 1'b0;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        hist_raddr_a = sum_a[AW-1:0];
        hist_raddr_b = sum_b[AW-1:0];
        head_re      = (state_reg == ST_HEAD);
    end

    assign m_valid          = m_valid_reg;
    assign m_match_length   = out_len_reg;
    assign m_match_distance = out_dist_reg;

`ifndef NO_ASSERTIONS
    // No request is taken during the clearing pass.
    a_clear_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_ready)
        else $error("request accepted during table clear");
    // A reported match is at least the minimum length and within the cap.
    a_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_match_length != '0) |->
            (m_match_length >= 9'(MIN_MATCH) && m_match_length <= max_match_reg))
        else $error("match length out of range");
    // A finished request leaves the sequencer idle with its result pending.
    a_done_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && (!m_valid || m_ready)) |=>
            (m_valid && state_reg == ST_IDLE))
        else $error("result not loaded on completion");
    // The candidate budget never exceeds the chain limit during a walk.
    a_left_down: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK && $past(state_reg) == ST_NEXT) |->
            left_reg <= max_chain_reg)
        else $error("candidate budget exceeded");
`endif
endmodule

### hdl/lzhc_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered and held while no read is issued. Uses no package items.
module lzhc_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

### hdl/lzhc_hash.sv
// Registered Knuth multiplicative hash of a three-byte word.
// Depends on lzhc_pkg for the multiplier constant.
module lzhc_hash #(
    parameter int HASH_BITS = 12
) (
    input  logic                 aclk,
    input  logic [23:0]          word,
    output logic [HASH_BITS-1:0] hash
);
    import lzhc_pkg::*;

    logic [31:0]          prod;
    logic [HASH_BITS-1:0] hash_reg;

    assign prod = {8'd0, word} * HASH_MULT;

    always_ff @(posedge aclk) begin
        hash_reg <= prod[31 -: HASH_BITS];
    end

    assign hash = hash_reg;
endmodule
